// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off during reset.
`define DAQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that holds in the cycle after a trigger condition.
`define DAQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/daq_pkg.sv =====
// Types and constants shared by the deque-with-cursor block.
package daq_pkg;

  // Widths of the external fields.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OUT_CNT_W = 5;

  // Operation codes carried by an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_QUERY      = 3'd0,
    OP_PUSH_LEFT  = 3'd1,
    OP_PUSH_RIGHT = 3'd2,
    OP_POP_LEFT   = 3'd3,
    OP_POP_RIGHT  = 3'd4,
    OP_CUR_LEFT   = 3'd5,
    OP_CUR_RIGHT  = 3'd6,
    OP_SET_CUR    = 3'd7
  } op_e;

  // Status codes carried by a result beat.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_AT_END = 2'd3
  } status_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOAD = 2'd1,
    S_SCAN = 2'd2,
    S_EMIT = 2'd3
  } state_e;

  // Input beat.
  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] item_value;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;
    logic signed [VAL_W-1:0] cursor_value;
    logic [OUT_CNT_W-1:0]    item_count;
    logic                    is_empty;
  } out_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_right;  // data moves one cell away from the left end
    logic shift_left;   // data moves one cell toward the left end
    logic load_tap;     // copy data into the read tap
    logic shift_tap;    // read taps move one cell toward the left end
  } cell_ctrl_t;

endpackage

// ===== src/daq_cell.sv =====
// One storage cell of the deque chain: an item register and a read tap.
module daq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  daq_pkg::cell_ctrl_t   ctrl_i,
  input  logic                  wr_en_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic [DATA_WIDTH-1:0] right_tap_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] tap_q, tap_d;

  // A direct write wins over a shift; otherwise take a neighbor or hold.
  always_comb begin
    if (wr_en_i) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift_right) begin
      data_d = left_data_i;
    end else if (ctrl_i.shift_left) begin
      data_d = right_data_i;
    end else begin
      data_d = data_q;
    end
  end

  // The tap copies the item, then walks toward the left end one cell a cycle.
  always_comb begin
    if (ctrl_i.load_tap) begin
      tap_d = data_q;
    end else if (ctrl_i.shift_tap) begin
      tap_d = right_tap_i;
    end else begin
      tap_d = tap_q;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tap_q  <= tap_d;
  end

  assign data_o = data_q;
  assign tap_o  = tap_q;

endmodule

// ===== src/deque_with_cursor.sv =====
// Top level of the bounded deque with a cursor, built as a chain of cells.
//
// Usage: an input beat (in_valid_i / in_ready_o, payload in_data_i) names one
// operation: query, push or pop at either end, move the cursor, or overwrite
// the item under the cursor. Every input beat yields exactly one result beat
// (out_valid_o / out_ready_i, payload out_data_o) with the popped value, a
// status, both end values, the cursor value and the item count.
// Items sit in cell order, leftmost in cell 0. The operation itself is done
// in the cycle the beat is accepted; the end and cursor values are then read
// out by a tap chain that walks one cell per cycle toward cell 0.
// Sequence: after acceptance the block loads the taps (S_LOAD), scans the items
// left after the step through cell 0's tap (S_SCAN), then writes the result
// register (S_EMIT); the next beat is taken only once the result is written.
// in_ready_o is high only while the block waits for a new operation; a result
// waiting in the output register does not hold off the next beat, only its
// own result. When the receiver stalls, the result is held unchanged.
// Reset empties the deque and parks the cursor; no clearing pass is needed.
module deque_with_cursor #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  daq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output daq_pkg::out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W = (DATA_WIDTH > daq_pkg::VAL_W) ? DATA_WIDTH
                                                                : daq_pkg::VAL_W;

  // Sequencer and pointer state.
  daq_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic             out_valid_q, out_valid_d;

  // Per-step payload state.
  daq_pkg::status_e      status_q, status_d;
  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  logic [DATA_WIDTH-1:0] left_q, left_d;
  logic [DATA_WIDTH-1:0] right_q, right_d;
  logic [DATA_WIDTH-1:0] cur_val_q, cur_val_d;
  daq_pkg::out_t         out_q, out_d;

  // Chain wiring.
  daq_pkg::cell_ctrl_t   ctrl;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
  logic [CAPACITY-1:0]   wr_en;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  do_push_left, do_push_right, do_set;

  // Helpers on the current pointers.
  logic             accept;
  logic             is_empty, is_full, cur_at_right, scan_last;
  logic [CNT_W-1:0] last_idx;
  logic [EXT_W-1:0] popped_ext, left_ext, right_ext, cur_ext;
  daq_pkg::op_e     op;

  assign accept       = in_valid_i && in_ready_o;
  assign op           = daq_pkg::op_e'(in_data_i.operation);
  assign is_empty     = (cnt_q == '0);
  assign is_full      = (cnt_q == CNT_W'(CAPACITY));
  assign last_idx     = cnt_q - CNT_W'(1);
  assign cur_at_right = (CNT_W'(cur_q) == last_idx);
  assign scan_last    = is_empty || (CNT_W'(scan_q) == last_idx);
  assign wr_data      = DATA_WIDTH'(in_data_i.item_value);

  // Write enables: left push lands in cell 0, right push just past the end,
  // a cursor write lands under the cursor.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_wr
    assign wr_en[k] = (do_push_left && (k == 0)) ||
                      (do_push_right && (cnt_q == CNT_W'(k))) ||
                      (do_set && (cur_q == IDX_W'(k)));
  end

  // The row of cells; the ends see zero from outside the chain.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_nb, right_nb, right_tap;
    if (k == 0) begin : g_first
      assign left_nb = '0;
    end else begin : g_inner_l
      assign left_nb = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_nb  = '0;
      assign right_tap = '0;
    end else begin : g_inner_r
      assign right_nb  = cell_data[k+1];
      assign right_tap = cell_tap[k+1];
    end
    daq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .wr_en_i     (wr_en[k]),
      .wr_data_i   (wr_data),
      .left_data_i (left_nb),
      .right_data_i(right_nb),
      .right_tap_i (right_tap),
      .data_o      (cell_data[k]),
      .tap_o       (cell_tap[k])
    );
  end

  // Widen or trim stored items to the result field width.
  assign popped_ext = EXT_W'(popped_q);
  assign left_ext   = EXT_W'(left_q);
  assign right_ext  = EXT_W'(right_q);
  assign cur_ext    = EXT_W'(cur_val_q);

  assign in_ready_o = (state_q == daq_pkg::S_IDLE);

  // Next state, operation decode and result capture.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cur_d         = cur_q;
    scan_d        = scan_q;
    status_d      = status_q;
    popped_d      = popped_q;
    left_d        = left_q;
    right_d       = right_q;
    cur_val_d     = cur_val_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    ctrl          = '0;
    do_push_left  = 1'b0;
    do_push_right = 1'b0;
    do_set        = 1'b0;

    case (state_q)
      daq_pkg::S_IDLE: begin
        if (accept) begin
          status_d = daq_pkg::ST_DONE;
          popped_d = '0;
          state_d  = daq_pkg::S_LOAD;
          case (op)
            daq_pkg::OP_PUSH_LEFT: begin
              if (is_full) begin
                status_d = daq_pkg::ST_FULL;
              end else begin
                do_push_left     = 1'b1;
                ctrl.shift_right = 1'b1;
                cur_d            = is_empty ? '0 : cur_q + IDX_W'(1);
                cnt_d            = cnt_q + CNT_W'(1);
              end
            end
            daq_pkg::OP_PUSH_RIGHT: begin
              if (is_full) begin
                status_d = daq_pkg::ST_FULL;
              end else begin
                do_push_right = 1'b1;
                cur_d         = is_empty ? '0 : cur_q;
                cnt_d         = cnt_q + CNT_W'(1);
              end
            end
            daq_pkg::OP_POP_LEFT: begin
              if (is_empty) begin
                status_d = daq_pkg::ST_EMPTY;
              end else begin
                popped_d        = left_q;
                ctrl.shift_left = 1'b1;
                cur_d           = (cur_q == '0) ? '0 : cur_q - IDX_W'(1);
                cnt_d           = cnt_q - CNT_W'(1);
              end
            end
            daq_pkg::OP_POP_RIGHT: begin
              if (is_empty) begin
                status_d = daq_pkg::ST_EMPTY;
              end else begin
                popped_d = right_q;
                cnt_d    = cnt_q - CNT_W'(1);
                // A popped cursor steps inward; with the last item gone it parks.
                if (cnt_q == CNT_W'(1)) begin
                  cur_d = '0;
                end else if (cur_at_right) begin
                  cur_d = cur_q - IDX_W'(1);
                end
              end
            end
            daq_pkg::OP_CUR_LEFT: begin
              if (is_empty) begin
                status_d = daq_pkg::ST_EMPTY;
              end else if ((cnt_q == CNT_W'(1)) || (cur_q == '0)) begin
                status_d = daq_pkg::ST_AT_END;
              end else begin
                cur_d = cur_q - IDX_W'(1);
              end
            end
            daq_pkg::OP_CUR_RIGHT: begin
              if (is_empty) begin
                status_d = daq_pkg::ST_EMPTY;
              end else if ((cnt_q == CNT_W'(1)) || cur_at_right) begin
                status_d = daq_pkg::ST_AT_END;
              end else begin
                cur_d = cur_q + IDX_W'(1);
              end
            end
            daq_pkg::OP_SET_CUR: begin
              if (is_empty) begin
                status_d = daq_pkg::ST_EMPTY;
              end else begin
                do_set = 1'b1;
              end
            end
            default: begin
              // Query changes nothing.
            end
          endcase
        end
      end

      daq_pkg::S_LOAD: begin
        ctrl.load_tap = 1'b1;
        scan_d        = '0;
        state_d       = daq_pkg::S_SCAN;
      end

      daq_pkg::S_SCAN: begin
        // Cell 0's tap shows the item at position scan_q.
        if (scan_q == '0) begin
          left_d = cell_tap[0];
        end
        if (scan_q == cur_q) begin
          cur_val_d = cell_tap[0];
        end
        if (CNT_W'(scan_q) == last_idx) begin
          right_d = cell_tap[0];
        end
        if (scan_last) begin
          state_d = daq_pkg::S_EMIT;
        end else begin
          ctrl.shift_tap = 1'b1;
          scan_d         = scan_q + IDX_W'(1);
        end
      end

      daq_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.popped_value = popped_ext[daq_pkg::VAL_W-1:0];
          out_d.status       = status_q;
          out_d.left_value   = is_empty ? '0 : left_ext[daq_pkg::VAL_W-1:0];
          out_d.right_value  = is_empty ? '0 : right_ext[daq_pkg::VAL_W-1:0];
          out_d.cursor_value = is_empty ? '0 : cur_ext[daq_pkg::VAL_W-1:0];
          out_d.item_count   = daq_pkg::OUT_CNT_W'(cnt_q);
          out_d.is_empty     = is_empty;
          state_d            = daq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = daq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= daq_pkg::S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    popped_q  <= popped_d;
    left_q    <= left_d;
    right_q   <= right_d;
    cur_val_q <= cur_val_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/daq_checker.sv =====
// Port-level checks of the deque with cursor, bound to the top level.
`include "assert_macros.svh"

module daq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input daq_pkg::out_t out_data_o
);

  // A stalled result beat stays put.
  `DAQ_ASSERT_NEXT(a_out_hold,
                   out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o),
                   "result beat changed while stalled")

  // The empty flag agrees with the count.
  `DAQ_ASSERT(a_empty_count,
              out_valid_o |-> (out_data_o.is_empty == (out_data_o.item_count == '0)),
              "empty flag disagrees with count")

  // A step that did not complete reports a zero popped value.
  `DAQ_ASSERT(a_popped_done,
              (out_valid_o && (out_data_o.status != daq_pkg::ST_DONE)) |->
                (out_data_o.popped_value == '0),
              "popped value on a failed step")

  // An empty deque shows zero at both ends and under the cursor.
  `DAQ_ASSERT(a_empty_zero,
              (out_valid_o && out_data_o.is_empty) |->
                ((out_data_o.left_value == '0) && (out_data_o.right_value == '0) &&
                 (out_data_o.cursor_value == '0)),
              "nonzero values while empty")

  // An empty-deque failure leaves the deque empty.
  `DAQ_ASSERT(a_empty_status,
              (out_valid_o && (out_data_o.status == daq_pkg::ST_EMPTY)) |->
                out_data_o.is_empty,
              "empty status on a filled deque")

endmodule

bind deque_with_cursor daq_checker u_daq_checker (.*);
